// ===== hdl/aap_pkg.sv =====
package aap_pkg;

    localparam int SLOT_W     = 5;
    localparam int ID_W       = 16;
    localparam int IN_COORD_W = 32;
    localparam int CNT_W      = 6;
    localparam int PAIR_W     = 5;

    // Pair matching stops after this many pairs; the scan itself runs on.
    localparam logic [PAIR_W-1:0] RESULT_CAP = 5'd31;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SCAN = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_LAST
    } t_state;

endpackage

// ===== hdl/aap_intf.sv =====
interface aap_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    cmd;
    logic        [aap_pkg::SLOT_W-1:0]       slot;
    logic        [aap_pkg::ID_W-1:0]         entity_id;
    logic                                    collide_enable;
    logic signed [aap_pkg::IN_COORD_W-1:0]   box_min_x;
    logic signed [aap_pkg::IN_COORD_W-1:0]   box_min_y;
    logic signed [aap_pkg::IN_COORD_W-1:0]   box_max_x;
    logic signed [aap_pkg::IN_COORD_W-1:0]   box_max_y;
    logic signed [aap_pkg::IN_COORD_W-1:0]   pos_x;
    logic signed [aap_pkg::IN_COORD_W-1:0]   pos_y;

    modport source (
        output valid, cmd, slot, entity_id, collide_enable,
               box_min_x, box_min_y, box_max_x, box_max_y, pos_x, pos_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, entity_id, collide_enable,
               box_min_x, box_min_y, box_max_x, box_max_y, pos_x, pos_y,
        output ready
    );
endinterface

interface aap_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [aap_pkg::ID_W-1:0]   first_id;
    logic [aap_pkg::ID_W-1:0]   second_id;
    logic                       last;

    modport source (output valid, hit, first_id, second_id, last, input ready);
    modport sink (input valid, hit, first_id, second_id, last, output ready);
endinterface

interface aap_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [aap_pkg::CNT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/aap_ram.sv =====
module aap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/aap_cell.sv =====
module aap_cell #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_wr,
    input  logic [W-1:0] i_wr_data,
    input  logic         i_shift,
    input  logic [W-1:0] i_next,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;

    // A direct write only happens while the ring sits at home.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_data <= i_wr_data;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hdl/aabb_all_pairs_overlap.sv =====
// Box overlap scan over a table of entity slots.
// Channels: i_in takes load and scan items, o_out returns result items, i_cfg
// writes entity_count (always ready). All use valid/ready; an item moves when
// both are high.
// A load item with an in-range slot writes that slot into the cell row and the
// query RAM; it gives no result and i_in stays ready.
// A scan item reads the named slot from the RAM, then rotates the cell row once
// past the comparator at cell 0, one slot per cycle unless a stall freezes it,
// and holds i_in low until it has queued its last result.
// Pairs come out in slot order; the final result carries last. A scan of a
// disabled slot gives one no-hit result after the RAM read, of an out-of-range
// slot without that read.
// Throughput: one load per cycle; scans do not overlap, since i_in stays low
// during one. Results sit in an output register, so the next item is
// taken while the last result of a scan still waits.
// A stalled receiver freezes the rotation when a second pair has to be queued.
// Reset clears entity_count, the control state and the output valid; slot
// contents are undefined until loaded.
module aabb_all_pairs_overlap #(
    parameter int MAX_ENTITIES = 32,
    parameter int COORD_BITS   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aap_in_if.sink        i_in,
    aap_out_if.source     o_out,
    aap_cfg_if.sink       i_cfg
);

    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int IW = AW + 1;
    localparam int XW = (IW > aap_pkg::SLOT_W) ? IW : aap_pkg::SLOT_W;
    localparam int NW = (IW > aap_pkg::CNT_W) ? IW : aap_pkg::CNT_W;
    localparam int SW = (COORD_BITS > aap_pkg::IN_COORD_W + 1) ?
                        COORD_BITS : aap_pkg::IN_COORD_W + 1;

    localparam logic signed [SW-1:0] SAT_HI =
        $signed(({{(SW-1){1'b0}}, 1'b1} << (COORD_BITS - 1)) - 1'b1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [aap_pkg::ID_W-1:0]     id;
        logic                         en;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [COORD_BITS-1:0] f_sat_add(
        input logic signed [aap_pkg::IN_COORD_W-1:0] a,
        input logic signed [aap_pkg::IN_COORD_W-1:0] b
    );
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[COORD_BITS-1:0];
    endfunction

    aap_pkg::t_state r_state, n_state;
    logic [aap_pkg::CNT_W-1:0]  r_cnt;
    logic [IW-1:0]              r_i, n_i;
    logic [aap_pkg::PAIR_W-1:0] r_k, n_k;
    logic                       r_pend_valid, n_pend_valid;
    logic [aap_pkg::ID_W-1:0]   r_pend_id, n_pend_id;
    t_entry                     r_q;
    logic                       r_o_valid;
    logic                       r_o_hit;
    logic [aap_pkg::ID_W-1:0]   r_o_first;
    logic [aap_pkg::ID_W-1:0]   r_o_second;
    logic                       r_o_last;

    logic                       w_in_acc;
    logic                       w_is_scan;
    logic [XW-1:0]              w_slot_x;
    logic                       w_slot_ok;
    logic [AW-1:0]              w_idx;
    logic                       w_load;
    t_entry                     w_new_entry;
    logic [ENTRY_W-1:0]         w_ram_rd;
    t_entry                     w_ram_entry;
    t_entry                     w_ring [MAX_ENTITIES];
    t_entry                     w_head;
    logic [NW-1:0]              w_cnt_x;
    logic [NW-1:0]              w_n_eff;
    logic                       w_out_free;
    logic                       w_cmp_en;
    logic                       w_overlap;
    logic                       w_match;
    logic                       w_stall;
    logic                       w_shift;
    logic                       w_push;
    logic                       w_push_hit;
    logic [aap_pkg::ID_W-1:0]   w_push_second;
    logic                       w_push_last;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_is_scan = (i_in.cmd == aap_pkg::CMD_SCAN);
    assign w_slot_x  = XW'(i_in.slot);
    assign w_slot_ok = (w_slot_x < XW'(MAX_ENTITIES));
    assign w_idx     = w_slot_x[AW-1:0];
    assign w_load    = w_in_acc && !w_is_scan && w_slot_ok;

    always_comb begin
        w_new_entry.id    = i_in.entity_id;
        w_new_entry.en    = i_in.collide_enable;
        w_new_entry.min_x = f_sat_add(i_in.box_min_x, i_in.pos_x);
        w_new_entry.min_y = f_sat_add(i_in.box_min_y, i_in.pos_y);
        w_new_entry.max_x = f_sat_add(i_in.box_max_x, i_in.pos_x);
        w_new_entry.max_y = f_sat_add(i_in.box_max_y, i_in.pos_y);
    end

    // Random-access copy of the table, used only to fetch the scanned box.
    aap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTITIES)
    ) u_query_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_idx),
        .i_wr_data (w_new_entry),
        .i_rd_addr (w_idx),
        .o_rd_data (w_ram_rd)
    );

    assign w_ram_entry = t_entry'(w_ram_rd);

    // Ring of cells: each shift moves the next slot into cell 0.
    for (genvar k = 0; k < MAX_ENTITIES; k++) begin : g_cell
        localparam int NXT = (k + 1) % MAX_ENTITIES;
        aap_cell #(
            .W (ENTRY_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_wr      (w_load && (w_idx == AW'(k))),
            .i_wr_data (w_new_entry),
            .i_shift   (w_shift),
            .i_next    (w_ring[NXT]),
            .o_data    (w_ring[k])
        );
    end

    assign w_head     = w_ring[0];
    assign w_cnt_x    = NW'(r_cnt);
    assign w_n_eff    = (w_cnt_x > NW'(MAX_ENTITIES)) ? NW'(MAX_ENTITIES) : w_cnt_x;
    assign w_out_free = !r_o_valid || o_out.ready;

    assign w_cmp_en  = (r_state == aap_pkg::ST_SCAN) && (NW'(r_i) < w_n_eff) &&
                       (r_k < aap_pkg::RESULT_CAP);
    assign w_overlap = !(w_head.min_x > r_q.max_x || w_head.min_y > r_q.max_y ||
                         r_q.min_x > w_head.max_x || r_q.min_y > w_head.max_y);
    assign w_match   = w_cmp_en && (w_head.id != r_q.id) && w_overlap;
    // A new pair pushes the held one out; wait if the output is still full.
    assign w_stall   = w_match && r_pend_valid && !w_out_free;
    assign w_shift   = (r_state == aap_pkg::ST_SCAN) && !w_stall;

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_k           = r_k;
        n_pend_valid  = r_pend_valid;
        n_pend_id     = r_pend_id;
        w_push        = 1'b0;
        w_push_hit    = 1'b0;
        w_push_second = '0;
        w_push_last   = 1'b0;
        case (r_state)
            aap_pkg::ST_IDLE: begin
                if (w_in_acc && w_is_scan) begin
                    n_state      = w_slot_ok ? aap_pkg::ST_FETCH : aap_pkg::ST_LAST;
                    n_i          = '0;
                    n_k          = '0;
                    n_pend_valid = 1'b0;
                end
            end
            aap_pkg::ST_FETCH: begin
                n_state = w_ram_entry.en ? aap_pkg::ST_SCAN : aap_pkg::ST_LAST;
            end
            aap_pkg::ST_SCAN: begin
                if (w_shift) begin
                    n_i = r_i + 1'b1;
                    if (w_match) begin
                        n_k          = r_k + 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_id    = w_head.id;
                        if (r_pend_valid) begin
                            w_push        = 1'b1;
                            w_push_hit    = 1'b1;
                            w_push_second = r_pend_id;
                        end
                    end
                    if (r_i == IW'(MAX_ENTITIES - 1)) begin
                        n_state = aap_pkg::ST_LAST;
                    end
                end
            end
            aap_pkg::ST_LAST: begin
                if (w_out_free) begin
                    w_push        = 1'b1;
                    w_push_hit    = r_pend_valid;
                    w_push_second = r_pend_valid ? r_pend_id : '0;
                    w_push_last   = 1'b1;
                    n_state       = aap_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aap_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_k          <= n_k;
            r_pend_valid <= n_pend_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cnt <= i_cfg.data;
            end
            if (w_push) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        if (r_state == aap_pkg::ST_IDLE && w_in_acc && w_is_scan && !w_slot_ok) begin
            r_q <= '0;
        end else if (r_state == aap_pkg::ST_FETCH) begin
            r_q <= w_ram_entry;
        end
        if (w_push) begin
            r_o_hit    <= w_push_hit;
            r_o_first  <= r_q.id;
            r_o_second <= w_push_second;
            r_o_last   <= w_push_last;
        end
    end

    assign i_in.ready      = (r_state == aap_pkg::ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_o_valid;
    assign o_out.hit       = r_o_hit;
    assign o_out.first_id  = r_o_first;
    assign o_out.second_id = r_o_second;
    assign o_out.last      = r_o_last;

endmodule

// ===== hdl/aap_checker.sv =====
module aap_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_cmd,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic                     i_out_hit,
    input logic [aap_pkg::ID_W-1:0] i_out_first_id,
    input logic [aap_pkg::ID_W-1:0] i_out_second_id,
    input logic                     i_out_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A no-hit result always closes its scan and carries no partner.
    a_nohit_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_last && (i_out_second_id == '0))
        else $error("malformed no-hit result");

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == aap_pkg::CMD_SCAN) |=> !i_in_ready)
        else $error("input ready right after a scan item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit) &&
            $stable(i_out_first_id) && $stable(i_out_second_id) && $stable(i_out_last))
        else $error("stalled result changed");

endmodule

bind aabb_all_pairs_overlap aap_checker u_aap_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_cmd        (i_in.cmd),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_hit       (o_out.hit),
    .i_out_first_id  (o_out.first_id),
    .i_out_second_id (o_out.second_id),
    .i_out_last      (o_out.last)
);
